/* sv/mra_pkg.sv */
// Shared constants, widths and the Q30 multiply for the rotated retarder pipeline.
// Used by mra_sincos, mueller_retarder_apply and its checker; depends on nothing.
package mra_pkg;

  localparam int STOKES_BITS_DEF = 24;
  localparam int ANGLE_BITS_DEF  = 16;

  localparam int QW           = 34;
  localparam int HORNER_STEPS = 7;
  localparam int TRIG_LAT     = 2 + 2 * HORNER_STEPS + 2;
  localparam int SQ_LAT       = 32;

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [29:0] Q30_HALF    = 30'h2000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  typedef logic signed [QW-1:0] q_t;

  localparam int SIN_SH [HORNER_STEPS] = '{8, 8, 7, 7, 6, 5, 3};
  localparam int COS_SH [HORNER_STEPS] = '{8, 8, 7, 6, 5, 4, 1};

  localparam logic [31:0] SIN_M [HORNER_STEPS] = '{
    32'(((64'd1 << 38) + 64'd209) / 64'd210),
    32'(((64'd1 << 38) + 64'd155) / 64'd156),
    32'(((64'd1 << 37) + 64'd109) / 64'd110),
    32'(((64'd1 << 37) + 64'd71) / 64'd72),
    32'(((64'd1 << 36) + 64'd41) / 64'd42),
    32'(((64'd1 << 35) + 64'd19) / 64'd20),
    32'(((64'd1 << 33) + 64'd5) / 64'd6)
  };

  localparam logic [31:0] COS_M [HORNER_STEPS] = '{
    32'(((64'd1 << 38) + 64'd181) / 64'd182),
    32'(((64'd1 << 38) + 64'd131) / 64'd132),
    32'(((64'd1 << 37) + 64'd89) / 64'd90),
    32'(((64'd1 << 36) + 64'd55) / 64'd56),
    32'(((64'd1 << 35) + 64'd29) / 64'd30),
    32'(((64'd1 << 34) + 64'd11) / 64'd12),
    32'(((64'd1 << 31) + 64'd1) / 64'd2)
  };

  function automatic q_t mul30(input q_t x, input q_t y);
    logic signed [2*QW-1:0] p;
    p = x * y + 68'sd536870912;
    return QW'(p >>> 30);
  endfunction

endpackage

/* sv/mra_sincos.sv */
// Pipelined Q30 sine and cosine of a fraction-of-turn angle: octant fold,
// Horner series with reciprocal-multiply division. Depends on mra_pkg.
module mra_sincos import mra_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] angle,
  output logic signed [31:0]    sn,
  output logic signed [31:0]    cs
);

  logic [31:0] turn;
  logic [29:0] r0;
  logic [29:0] rf;
  logic        fold;
  logic [60:0] xp;

  logic [29:0] x1;
  logic [1:0]  q1;
  logic        sw1;

  logic [29:0] hx  [HORNER_STEPS+1];
  logic [29:0] hx2 [HORNER_STEPS+1];
  logic [30:0] hts [HORNER_STEPS+1];
  logic [30:0] htc [HORNER_STEPS+1];
  logic [1:0]  hq  [HORNER_STEPS+1];
  logic        hsw [HORNER_STEPS+1];

  logic [29:0] px  [HORNER_STEPS];
  logic [29:0] px2 [HORNER_STEPS];
  logic [29:0] pas [HORNER_STEPS];
  logic [29:0] pac [HORNER_STEPS];
  logic [1:0]  pq  [HORNER_STEPS];
  logic        psw [HORNER_STEPS];

  logic [60:0] x2p;
  logic [60:0] fsp;
  logic [30:0] fs;
  logic [30:0] fc;
  logic [1:0]  fq;
  logic        fsw;
  logic [30:0] va;
  logic [30:0] vb;

  always_comb begin
    turn = {angle, {(32-ANGLE_BITS){1'b0}}};
    r0   = turn[29:0];
    fold = r0 > Q30_HALF;
    rf   = fold ? 30'(Q30_ONE - {1'b0, r0}) : r0;
    xp   = 61'(rf) * 61'(HALF_PI_Q30) + 61'(Q30_HALF);
    x2p  = 61'(x1) * 61'(x1) + 61'(Q30_HALF);
    fsp  = 61'(hx[HORNER_STEPS]) * 61'(hts[HORNER_STEPS]) + 61'(Q30_HALF);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1  <= xp[59:30];
      q1  <= turn[31:30];
      sw1 <= fold;
      hx[0]  <= x1;
      hx2[0] <= x2p[59:30];
      hts[0] <= Q30_ONE;
      htc[0] <= Q30_ONE;
      hq[0]  <= q1;
      hsw[0] <= sw1;
      fs  <= fsp[60:30];
      fc  <= htc[HORNER_STEPS];
      fq  <= hq[HORNER_STEPS];
      fsw <= hsw[HORNER_STEPS];
    end
  end

  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
    logic [60:0] as_p;
    logic [60:0] ac_p;
    logic [61:0] bs_p;
    logic [61:0] bc_p;
    logic [61:0] bs_q;
    logic [61:0] bc_q;

    always_comb begin
      as_p = 61'(hx2[k]) * 61'(hts[k]) + 61'(Q30_HALF);
      ac_p = 61'(hx2[k]) * 61'(htc[k]) + 61'(Q30_HALF);
      bs_p = 62'(pas[k]) * 62'(SIN_M[k]);
      bc_p = 62'(pac[k]) * 62'(COS_M[k]);
      bs_q = bs_p >> (30 + SIN_SH[k]);
      bc_q = bc_p >> (30 + COS_SH[k]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pas[k] <= as_p[59:30];
        pac[k] <= ac_p[59:30];
        px[k]  <= hx[k];
        px2[k] <= hx2[k];
        pq[k]  <= hq[k];
        psw[k] <= hsw[k];
        hts[k+1] <= Q30_ONE - bs_q[30:0];
        htc[k+1] <= Q30_ONE - bc_q[30:0];
        hx[k+1]  <= px[k];
        hx2[k+1] <= px2[k];
        hq[k+1]  <= pq[k];
        hsw[k+1] <= psw[k];
      end
    end
  end

  always_comb begin
    va = fsw ? fc : fs;
    vb = fsw ? fs : fc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (fq)
        2'd0: begin
          sn <= $signed({1'b0, va});
          cs <= $signed({1'b0, vb});
        end
        2'd1: begin
          sn <= $signed({1'b0, vb});
          cs <= -$signed({1'b0, va});
        end
        2'd2: begin
          sn <= -$signed({1'b0, va});
          cs <= -$signed({1'b0, vb});
        end
        default: begin
          sn <= -$signed({1'b0, vb});
          cs <= $signed({1'b0, va});
        end
      endcase
    end
  end

endmodule

/* sv/mueller_retarder_apply.sv */
// Top level: rotated linear retarder and diattenuator applied to a Stokes vector.
// Depends on mra_pkg and mra_sincos.
//
// One item enters per clock; the whole
// pipeline holds while the output waits. The 32-stage square root of Tx*Ty,
// one result bit per stage, sets the latency; the two sine/cosine units run
// beside it, then four stages build the matrix, multiply and round.
module mueller_retarder_apply import mra_pkg::*; #(
  parameter int STOKES_BITS = STOKES_BITS_DEF,
  parameter int ANGLE_BITS  = ANGLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // s0_in, s1_in, s2_in, s3_in, axis_angle, trans_x, phase_x, trans_y, phase_y
  input  logic [((4*STOKES_BITS+3*ANGLE_BITS+32+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // s0_out, s1_out, s2_out, s3_out
  output logic [((4*STOKES_BITS+7)/8)*8-1:0] m_tdata,
  // saturated
  output logic [0:0] m_tuser
);

  localparam int SB      = STOKES_BITS;
  localparam int AB      = ANGLE_BITS;
  localparam int OUT_TW  = ((4*SB+7)/8)*8;
  localparam int LAT     = SQ_LAT + 4;
  localparam int ANG_DLY = SQ_LAT - TRIG_LAT;
  localparam int PW      = QW + SB;
  localparam int ACCW    = PW + 2;
  localparam logic signed [ACCW-1:0] SMAX =
    $signed({{(ACCW-SB+1){1'b0}}, {(SB-1){1'b1}}});
  localparam logic signed [ACCW-1:0] SMIN = ~SMAX;

  typedef logic signed [SB-1:0] stk_t;

  logic en;
  logic [LAT-1:0] vld;

  stk_t        s_in [4];
  logic [AB-1:0] axis_angle;
  logic [AB-1:0] phase_x;
  logic [AB-1:0] phase_y;
  logic [15:0] trans_x;
  logic [15:0] trans_y;

  stk_t        sdl [SQ_LAT][4];
  logic [15:0] txd [SQ_LAT];
  logic [15:0] tyd [SQ_LAT];
  logic [AB-1:0] adl_ax [ANG_DLY];
  logic [AB-1:0] adl_ph [ANG_DLY];

  logic [31:0] sq_prod [SQ_LAT];
  logic [30:0] sq_root [SQ_LAT];
  logic [33:0] sq_rem  [SQ_LAT];

  logic signed [31:0] ax_sn;
  logic signed [31:0] ax_cs;
  logic signed [31:0] ph_sn;
  logic signed [31:0] ph_cs;

  q_t g_q;
  q_t c_q;
  q_t s_q;
  q_t cp_q;
  q_t sp_q;
  q_t a_q;
  q_t d_q;
  logic signed [16:0] d17;

  q_t r1_a, r1_c, r1_s, r1_gc, r1_gs, r1_cc, r1_ss, r1_cs, r1_dc, r1_ds;
  stk_t r1_sv [4];
  q_t m [4][4];
  stk_t r2_sv [4];
  logic signed [PW-1:0] r3_p [4][4];

  logic signed [ACCW-1:0] acc [4];
  logic signed [ACCW-1:0] rnd [4];
  stk_t o_s [4];
  logic [3:0] clip;
  logic o_sat;

  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];
  assign m_tdata  = OUT_TW'({o_s[3], o_s[2], o_s[1], o_s[0]});
  assign m_tuser  = o_sat;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s_in[k] = $signed(s_tdata[k*SB +: SB]);
    end
    axis_angle = s_tdata[4*SB +: AB];
    trans_x    = s_tdata[4*SB+AB +: 16];
    phase_x    = s_tdata[4*SB+AB+16 +: AB];
    trans_y    = s_tdata[4*SB+2*AB+16 +: 16];
    phase_y    = s_tdata[4*SB+2*AB+32 +: AB];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sdl[0] <= s_in;
      txd[0] <= trans_x;
      tyd[0] <= trans_y;
      for (int i = 1; i < SQ_LAT; i++) begin
        sdl[i] <= sdl[i-1];
        txd[i] <= txd[i-1];
        tyd[i] <= tyd[i-1];
      end
      adl_ax[0] <= AB'({axis_angle, 1'b0});
      adl_ph[0] <= phase_x - phase_y;
      for (int i = 1; i < ANG_DLY; i++) begin
        adl_ax[i] <= adl_ax[i-1];
        adl_ph[i] <= adl_ph[i-1];
      end
      sq_prod[0] <= 32'(trans_x) * 32'(trans_y);
      sq_root[0] <= '0;
      sq_rem[0]  <= '0;
    end
  end

  for (genvar j = 1; j < SQ_LAT; j++) begin : g_sqrt
    localparam int K = SQ_LAT - 1 - j;
    logic [1:0]  pair;
    logic [33:0] rm;
    logic [33:0] trial;

    if (K >= 15) begin : g_pair
      assign pair = sq_prod[j-1][2*K-29 -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    always_comb begin
      rm    = {sq_rem[j-1][31:0], pair};
      trial = {1'b0, sq_root[j-1], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_prod[j] <= sq_prod[j-1];
        if (rm >= trial) begin
          sq_rem[j]  <= rm - trial;
          sq_root[j] <= {sq_root[j-1][29:0], 1'b1};
        end else begin
          sq_rem[j]  <= rm;
          sq_root[j] <= {sq_root[j-1][29:0], 1'b0};
        end
      end
    end
  end

  mra_sincos #(.ANGLE_BITS(AB)) u_axis (
    .clk   (clk),
    .en    (en),
    .angle (adl_ax[ANG_DLY-1]),
    .sn    (ax_sn),
    .cs    (ax_cs)
  );

  mra_sincos #(.ANGLE_BITS(AB)) u_phase (
    .clk   (clk),
    .en    (en),
    .angle (adl_ph[ANG_DLY-1]),
    .sn    (ph_sn),
    .cs    (ph_cs)
  );

  always_comb begin
    g_q  = {{(QW-31){1'b0}}, sq_root[SQ_LAT-1]};
    c_q  = QW'(ax_cs);
    s_q  = QW'(ax_sn);
    cp_q = QW'(ph_cs);
    sp_q = QW'(ph_sn);
    a_q  = {{(QW-31){1'b0}}, 17'(txd[SQ_LAT-1]) + 17'(tyd[SQ_LAT-1]), 14'b0};
    d17  = $signed({1'b0, txd[SQ_LAT-1]}) - $signed({1'b0, tyd[SQ_LAT-1]});
    d_q  = QW'($signed({d17, 14'b0}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_a  <= a_q;
      r1_c  <= c_q;
      r1_s  <= s_q;
      r1_gc <= mul30(g_q, cp_q);
      r1_gs <= mul30(g_q, sp_q);
      r1_cc <= mul30(c_q, c_q);
      r1_ss <= mul30(s_q, s_q);
      r1_cs <= mul30(c_q, s_q);
      r1_dc <= mul30(d_q, c_q);
      r1_ds <= mul30(d_q, s_q);
      r1_sv <= sdl[SQ_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m[0][0] <= r1_a;
      m[0][1] <= r1_dc;
      m[0][2] <= r1_ds;
      m[0][3] <= '0;
      m[1][0] <= r1_dc;
      m[1][1] <= mul30(r1_a, r1_cc) + mul30(r1_gc, r1_ss);
      m[1][2] <= mul30(r1_a, r1_cs) - mul30(r1_gc, r1_cs);
      m[1][3] <= -mul30(r1_s, r1_gs);
      m[2][0] <= r1_ds;
      m[2][1] <= mul30(r1_a, r1_cs) - mul30(r1_gc, r1_cs);
      m[2][2] <= mul30(r1_a, r1_ss) + mul30(r1_gc, r1_cc);
      m[2][3] <= mul30(r1_c, r1_gs);
      m[3][0] <= '0;
      m[3][1] <= mul30(r1_gs, r1_s);
      m[3][2] <= -mul30(r1_gs, r1_c);
      m[3][3] <= r1_gc;
      r2_sv   <= r1_sv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          r3_p[i][j] <= PW'(m[i][j]) * PW'(r2_sv[j]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc[i] = ACCW'(r3_p[i][0]) + ACCW'(r3_p[i][1])
             + ACCW'(r3_p[i][2]) + ACCW'(r3_p[i][3]) + $signed(ACCW'(Q30_HALF));
      rnd[i] = acc[i] >>> 30;
      clip[i] = (rnd[i] > SMAX) || (rnd[i] < SMIN);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        priority if (rnd[i] > SMAX) begin
          o_s[i] <= SB'(SMAX);
        end else if (rnd[i] < SMIN) begin
          o_s[i] <= SB'(SMIN);
        end else begin
          o_s[i] <= SB'(rnd[i]);
        end
      end
      o_sat <= |clip;
    end
  end

endmodule

/* dv/mueller_retarder_apply_checker.sv */
// Checker for mueller_retarder_apply: watches both stream channels, predicts each result
// from a fixed-point Mueller model and compares field by field. Depends on mra_pkg widths.
module mueller_retarder_apply_checker import mra_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tready,
  input  logic [175:0] s_tdata,
  input  logic m_tvalid,
  input  logic m_tready,
  input  logic [95:0] m_tdata,
  input  logic [0:0] m_tuser,
  output int errors,
  output int pending,
  output int results_seen,
  output int sat_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = STOKES_BITS_DEF;
  localparam int AB = ANGLE_BITS_DEF;
  localparam longint SMAX = (64'sd1 <<< (SB - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam longint ONE = 64'sd1 <<< 30;
  localparam longint HALF = 64'sd1 <<< 29;

  typedef struct packed {
    logic [SB-1:0] s3, s2, s1, s0;
    logic sat;
  } stokes_result_t;

  stokes_result_t stokes_q[$];

  function automatic longint shr_round(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint qmul(longint x, longint y);
    return shr_round(x * y, 30);
  endfunction

  function automatic longint taylor(longint x2, bit is_sin);
    int den_s[7] = '{210, 156, 110, 72, 42, 20, 6};
    int den_c[7] = '{182, 132, 90, 56, 30, 12, 2};
    longint t;
    t = ONE;
    for (int i = 0; i < 7; i++)
      t = ONE - ((x2 * t + HALF) >>> 30) / (is_sin ? den_s[i] : den_c[i]);
    return t;
  endfunction

  function automatic void trig(logic [AB-1:0] ang, output longint sn, output longint cs);
    longint turn, r, x, x2, s0, c0, tmp;
    int quad;
    turn = longint'(ang) <<< (32 - AB);
    quad = (turn >>> 30) & 3;
    r = turn & (ONE - 1);
    x = 0;
    tmp = 0;
    if (r > HALF) r = ONE - r;
    x = (r * 64'sd1686629713 + HALF) >>> 30;
    x2 = (x * x + HALF) >>> 30;
    s0 = (x * taylor(x2, 1) + HALF) >>> 30;
    c0 = taylor(x2, 0);
    if ((turn & (ONE - 1)) > HALF) begin
      tmp = s0; s0 = c0; c0 = tmp;
    end
    case (quad)
      0: begin sn = s0; cs = c0; end
      1: begin sn = c0; cs = -s0; end
      2: begin sn = -s0; cs = -c0; end
      default: begin sn = -c0; cs = s0; end
    endcase
  endfunction

  function automatic longint root(longint v);
    longint res, b;
    res = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic stokes_result_t apply_element(logic [175:0] d);
    longint sv[4], m[4][4];
    longint c, s, cp, sp, a, dd, g, gc, gs, cc, ss, csx, acc, v, tx, ty;
    logic [AB-1:0] ang, ph;
    stokes_result_t r;
    for (int i = 0; i < 4; i++) sv[i] = longint'($signed(d[i*SB +: SB]));
    ang = d[96 +: 16] * 2;
    ph = d[128 +: 16] - d[160 +: 16];
    tx = d[112 +: 16];
    ty = d[144 +: 16];
    trig(ang, s, c);
    trig(ph, sp, cp);
    a = (tx + ty) * 16384;
    dd = (tx - ty) * 16384;
    g = root((tx * ty) <<< 30);
    gc = qmul(g, cp); gs = qmul(g, sp);
    cc = qmul(c, c); ss = qmul(s, s); csx = qmul(c, s);
    m[0] = '{a, qmul(dd, c), qmul(dd, s), 0};
    m[1] = '{qmul(dd, c), qmul(a, cc) + qmul(gc, ss), qmul(a, csx) - qmul(gc, csx),
             -qmul(s, gs)};
    m[2] = '{qmul(dd, s), m[1][2], qmul(a, ss) + qmul(gc, cc), qmul(c, gs)};
    m[3] = '{0, qmul(gs, s), -qmul(gs, c), gc};
    r = '0;
    for (int i = 0; i < 4; i++) begin
      acc = 0;
      for (int j = 0; j < 4; j++) acc += m[i][j] * sv[j];
      v = shr_round(acc, 30);
      if (v > SMAX) begin v = SMAX; r.sat = 1; end
      if (v < SMIN) begin v = SMIN; r.sat = 1; end
      case (i)
        0: r.s0 = v[SB-1:0];
        1: r.s1 = v[SB-1:0];
        2: r.s2 = v[SB-1:0];
        default: r.s3 = v[SB-1:0];
      endcase
    end
    return r;
  endfunction

  assign pending = stokes_q.size();

  always @(posedge clk) begin
    stokes_result_t e;
    int nerr;
    nerr = 0;
    if (rst) begin
      errors <= 0;
      results_seen <= 0;
      sat_seen <= 0;
    end else begin
      if (s_tvalid && s_tready) stokes_q.push_back(apply_element(s_tdata));
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (m_tuser[0]) sat_seen <= sat_seen + 1;
        if (stokes_q.size() == 0) begin
          $error("unexpected result transfer %h", m_tdata);
          nerr++;
        end else begin
          e = stokes_q.pop_front();
          if (m_tdata[0 +: SB] !== e.s0) begin
            $error("s0_out expected %h actual %h", e.s0, m_tdata[0 +: SB]);
            nerr++;
          end
          if (m_tdata[SB +: SB] !== e.s1) begin
            $error("s1_out expected %h actual %h", e.s1, m_tdata[SB +: SB]);
            nerr++;
          end
          if (m_tdata[2*SB +: SB] !== e.s2) begin
            $error("s2_out expected %h actual %h", e.s2, m_tdata[2*SB +: SB]);
            nerr++;
          end
          if (m_tdata[3*SB +: SB] !== e.s3) begin
            $error("s3_out expected %h actual %h", e.s3, m_tdata[3*SB +: SB]);
            nerr++;
          end
          if (m_tuser[0] !== e.sat) begin
            $error("saturated expected %b actual %b", e.sat, m_tuser[0]);
            nerr++;
          end
        end
      end
      errors <= errors + nerr;
    end
  end
endmodule

/* dv/mueller_retarder_apply_tb.sv */
// Testbench top for mueller_retarder_apply: drives directed and random optical elements
// and Stokes vectors with random idling and backpressure. Depends on the checker and mueller_retarder_apply.
module mueller_retarder_apply_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 1300;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [175:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [95:0] m_tdata;
  logic [0:0] m_tuser;
  int errors, pending, results_seen, sat_seen;
  int sent = 0;
  int rx_idle = 0;
  bit quiet = 0;
  bit hold_off = 0;

  always #6 clk = ~clk;

  mueller_retarder_apply DUT (.*);

  mueller_retarder_apply_checker checker_i (.*);

  function automatic logic [175:0] pack_item(logic [23:0] s0, s1, s2, s3,
      logic [15:0] ang, tx, px, ty, py);
    return {py, ty, px, tx, ang, s3, s2, s1, s0};
  endfunction

  function automatic logic [15:0] rand_trans();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [23:0] rand_stokes();
    case ($urandom_range(0, 7))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 65536));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send(logic [175:0] d);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  always @(posedge clk) begin
    if (rst || hold_off) begin
      m_tready <= 0;
    end else if (rx_idle > 0) begin
      m_tready <= 0;
      rx_idle <= rx_idle - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      m_tready <= 0;
      rx_idle <= int'($urandom_range(0, 2));
    end else begin
      m_tready <= 1;
    end
  end

  initial begin
    logic [23:0] ext[4];
    ext = '{24'h7fffff, 24'h800000, 24'h000000, 24'h010000};
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(pack_item(24'h010000, 24'h010000, 0, 0, 0, 16'd32768, 0, 16'd32768, 0));
    send(pack_item(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff, 16'hffff,
                   16'hffff, 16'hffff, 16'hffff, 0));
    send(pack_item(24'h800000, 24'h800000, 24'h800000, 24'h800000, 16'h8000,
                   16'hffff, 0, 16'hffff, 16'hffff));
    send(pack_item(24'h010000, 0, 24'h010000, 0, 16'h2000, 0, 16'h4000, 16'd32768, 0));
    send(pack_item(24'h010000, 0, 0, 24'h010000, 16'h1000, 16'd32768, 16'h4000, 0, 0));
    send(pack_item(24'h010000, 24'h8000, 0, 24'h8000, 16'h4000, 0, 0, 0, 0));
    for (int q = 0; q < 8; q++)
      send(pack_item(ext[q%4], ext[(q+1)%4], ext[(q+2)%4], ext[(q+3)%4], 16'(q * 16'h2000),
                     16'd32768, 16'(q * 16'h2000), 16'd16384, 16'h2000));
    send(pack_item(24'h123456, 24'hfedcba, 24'h0f0f0f, 24'hf0f0f0, 16'h5555, 16'haaaa,
                   16'h5555, 16'h5555, 16'haaaa));
    send(pack_item(24'h010000, 24'h010000, 0, 0, 16'h0001, 16'd1, 16'h0001, 16'd1, 16'hffff));
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) fork
        begin
          hold_off = 1;
          repeat (200) @(posedge clk);
          hold_off = 0;
        end
      join_none
      if (i == N_RANDOM - 150) quiet = 1;
      send(pack_item(rand_stokes(), rand_stokes(), rand_stokes(), rand_stokes(),
                     16'($urandom), rand_trans(), 16'($urandom), rand_trans(),
                     16'($urandom)));
    end
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d elements applied, %0d results checked, %0d saturated",
             sent, results_seen, sat_seen);
    if (errors == 0 && pending == 0)
      $display("mueller_retarder_apply verification clean");
    else
      $display("mueller_retarder_apply verification failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("mueller_retarder_apply verification failed");
    $finish;
  end
endmodule

/* mueller_retarder_apply.f */
sv/mra_pkg.sv
sv/mra_sincos.sv
sv/mueller_retarder_apply.sv
dv/mueller_retarder_apply_checker.sv
dv/mueller_retarder_apply_tb.sv
